// ----- design/button_press_classifier_queue_macros.svh -----
// assertion helpers for the button press classifier queue
`ifndef BUTTON_PRESS_CLASSIFIER_QUEUE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BPCQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BPCQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bpcq_pkg.sv -----
package bpcq_pkg;

    localparam int TIME_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int EV_W      = 2;
    localparam int CFG_IDX_W = 2;

    // event codes held in the ring and returned by a pop
    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW  = 2'd0,
        CFG_LONG_LIMIT  = 2'd1,
        CFG_SHORT_LIMIT = 2'd2,
        CFG_MIN_PRESS   = 2'd3
    } cfg_idx_t;

    // item kinds
    localparam logic ACT_POLL = 1'b0;
    localparam logic ACT_POP  = 1'b1;

endpackage

// ----- design/button_press_classifier_queue.sv -----
// button press classifier with event queue
//
// item channel (item_valid / item_stall): each word is a poll (action 0) carrying the
// raw pin level and a millisecond timestamp, or a pop (action 1). a poll tracks the
// press and may push a short or long event into the ring; it returns no word.
// a pop returns one word on the result channel (res_valid / res_stall): the oldest
// event, or none when the ring is empty.
// config channel (cfg_valid / cfg_ready, always ready) writes polarity and the three
// time limits; write only while no pop result is outstanding.
// a pop result passes through the ring read register, then the result buffer, before
// it can be taken. throughput: one item per cycle while item_stall is low, set by the
// single ring port pair (one write per poll, one registered read per pop).
// item_stall comes only from registers: it rises when the three-word result buffer
// plus the read in flight would fill, so up to two results may wait on a stalled
// receiver while items keep flowing.
// reset: press tracking and ring pointers clear, config returns to its defaults
// (active low, 800 / 300 / 30 ms); ring contents are not cleared.
module button_press_classifier_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              action,
    input  logic                              pin_level,
    input  logic [bpcq_pkg::TIME_W-1:0]       now_ms,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [bpcq_pkg::EV_W-1:0]         event_res,
    // config channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpcq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpcq_pkg::LIMIT_W-1:0]      cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam int BUF_DEPTH = 3;

    // configuration registers
    logic                             active_low_reg;
    logic [bpcq_pkg::LIMIT_W-1:0]     long_limit_reg;
    logic [bpcq_pkg::LIMIT_W-1:0]     short_limit_reg;
    logic [bpcq_pkg::LIMIT_W-1:0]     min_press_reg;

    // press tracking
    logic                             pressed_reg, pressed_next;
    logic                             long_given_reg, long_given_next;
    logic [bpcq_pkg::TIME_W-1:0]      start_reg, start_next;

    // ring pointers and storage
    logic [PTR_W-1:0]                 wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]                 rd_ptr_reg, rd_ptr_next;
    logic [bpcq_pkg::EV_W-1:0]        ring_mem [QUEUE_DEPTH];
    logic [bpcq_pkg::EV_W-1:0]        rdata_reg;

    // read stage
    logic                             s1_valid_reg;
    logic                             s1_none_reg;
    logic [bpcq_pkg::EV_W-1:0]        s1_event;

    // result buffer, head in slot 0
    logic [bpcq_pkg::EV_W-1:0]        fq_reg [BUF_DEPTH];
    logic [bpcq_pkg::EV_W-1:0]        fq_next [BUF_DEPTH];
    logic [1:0]                       cnt_reg, cnt_next;
    logic [1:0]                       wr_idx;
    logic [2:0]                       in_flight;

    // per item decode
    logic                             item_acc;
    logic                             poll_acc;
    logic                             pop_acc;
    logic                             res_deq;
    logic                             down;
    logic [bpcq_pkg::TIME_W-1:0]      held;
    logic                             long_hit;
    logic                             short_hit;
    logic                             push_req;
    logic                             push_en;
    logic [bpcq_pkg::EV_W-1:0]        push_ev;
    logic [PTR_W-1:0]                 wr_ptr_inc;
    logic [PTR_W-1:0]                 rd_ptr_inc;
    logic                             ring_empty;
    logic                             ring_full;

    assign cfg_ready = 1'b1;

    // handshakes
    assign in_flight  = {1'b0, cnt_reg} + {2'b00, s1_valid_reg};
    assign item_stall = (in_flight >= 3'(BUF_DEPTH));
    assign item_acc   = item_valid && !item_stall;
    assign poll_acc   = item_acc && (action == bpcq_pkg::ACT_POLL);
    assign pop_acc    = item_acc && (action == bpcq_pkg::ACT_POP);
    assign res_valid  = (cnt_reg != 2'd0);
    assign res_deq    = res_valid && !res_stall;
    assign event_res  = fq_reg[0];

    // ring pointer arithmetic, wraps at any depth
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
    assign ring_empty = (rd_ptr_reg == wr_ptr_reg);
    assign ring_full  = (wr_ptr_inc == rd_ptr_reg);

    // press classification: hold time wraps modulo 2^32
    assign down      = active_low_reg ? !pin_level : pin_level;
    assign held      = now_ms - start_reg;
    assign long_hit  = held > {{(bpcq_pkg::TIME_W-bpcq_pkg::LIMIT_W){1'b0}}, long_limit_reg};
    assign short_hit = (held > {{(bpcq_pkg::TIME_W-bpcq_pkg::LIMIT_W){1'b0}}, min_press_reg})
                    && (held < {{(bpcq_pkg::TIME_W-bpcq_pkg::LIMIT_W){1'b0}}, short_limit_reg});

    always_comb
    begin
        pressed_next    = pressed_reg;
        long_given_next = long_given_reg;
        start_next      = start_reg;
        push_req        = 1'b0;
        push_ev         = bpcq_pkg::EV_NONE;
        if (poll_acc)
        begin
            if (!pressed_reg)
            begin
                if (down)
                begin
                    pressed_next    = 1'b1;
                    long_given_next = 1'b0;
                    start_next      = now_ms;
                end
            end
            else if (down)
            begin
                if (!long_given_reg && long_hit)
                begin
                    long_given_next = 1'b1;
                    push_req        = 1'b1;
                    push_ev         = bpcq_pkg::EV_LONG;
                end
            end
            else
            begin
                // release
                if (!long_given_reg && short_hit)
                begin
                    push_req = 1'b1;
                    push_ev  = bpcq_pkg::EV_SHORT;
                end
                pressed_next    = 1'b0;
                long_given_next = 1'b0;
            end
        end
    end

    // a push into a full ring is dropped
    assign push_en     = push_req && !ring_full;
    assign wr_ptr_next = push_en ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = (pop_acc && !ring_empty) ? rd_ptr_inc : rd_ptr_reg;

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            ring_mem[wr_ptr_reg] <= push_ev;
        end
        if (pop_acc)
        begin
            rdata_reg <= ring_mem[rd_ptr_reg];
        end
    end

    assign s1_event = s1_none_reg ? bpcq_pkg::EV_NONE : rdata_reg;

    // result buffer: shift on dequeue, fill behind the last word
    assign wr_idx   = cnt_reg - {1'b0, res_deq};
    assign cnt_next = cnt_reg + {1'b0, s1_valid_reg} - {1'b0, res_deq};

    always_comb
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            fq_next[i] = fq_reg[i];
        end
        if (res_deq)
        begin
            for (int i = 0; i < BUF_DEPTH - 1; i++)
            begin
                fq_next[i] = fq_reg[i+1];
            end
        end
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            if (s1_valid_reg && (wr_idx == 2'(i)))
            begin
                fq_next[i] = s1_event;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            fq_reg[i] <= fq_next[i];
        end
        if (pop_acc)
        begin
            s1_none_reg <= ring_empty;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg  <= 1'b1;
            long_limit_reg  <= 16'd800;
            short_limit_reg <= 16'd300;
            min_press_reg   <= 16'd30;
            pressed_reg     <= 1'b0;
            long_given_reg  <= 1'b0;
            start_reg       <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            s1_valid_reg    <= 1'b0;
            cnt_reg         <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (bpcq_pkg::cfg_idx_t'(cfg_index))
                    bpcq_pkg::CFG_ACTIVE_LOW:  active_low_reg  <= cfg_data[0];
                    bpcq_pkg::CFG_LONG_LIMIT:  long_limit_reg  <= cfg_data;
                    bpcq_pkg::CFG_SHORT_LIMIT: short_limit_reg <= cfg_data;
                    bpcq_pkg::CFG_MIN_PRESS:   min_press_reg   <= cfg_data;
                    default: ;
                endcase
            end
            pressed_reg    <= pressed_next;
            long_given_reg <= long_given_next;
            start_reg      <= start_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            s1_valid_reg   <= pop_acc;
            cnt_reg        <= cnt_next;
        end
    end

    `include "button_press_classifier_queue_macros.svh"

    `BPCQ_ASSERT_IMP(a_buf_room, s1_valid_reg, (cnt_reg != 2'd3) || res_deq, "buffer overflow")
    `BPCQ_ASSERT_NXT(a_push_fills, push_en, wr_ptr_reg != rd_ptr_reg, "push left ring empty")
    `BPCQ_ASSERT_NXT(a_empty_pop, pop_acc && ring_empty, s1_valid_reg && s1_none_reg, "bad none")
    `BPCQ_ASSERT_IMP(a_long_pressed, long_given_reg, pressed_reg, "long event without press")

endmodule

// ----- dv/button_press_classifier_queue_tb.sv -----
`timescale 1ns / 1ps

module button_press_classifier_queue_tb;

    localparam int TIME_W    = bpcq_pkg::TIME_W;
    localparam int LIMIT_W   = bpcq_pkg::LIMIT_W;
    localparam int EV_W      = bpcq_pkg::EV_W;
    localparam int CFG_IDX_W = bpcq_pkg::CFG_IDX_W;

    localparam int RING_DEPTH  = 8;
    localparam int CLK_HALF    = 6;
    localparam int QUIET_LIMIT = 1000;   // cycles with no word moving on any channel
    localparam int POLL_SETTLE = 4;      // cycles for a poll in flight to reach the ring

    // dut ports
    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic                 action;
    logic                 pin_level;
    logic [TIME_W-1:0]    now_ms;
    logic                 res_valid;
    logic                 res_stall;
    logic [EV_W-1:0]      event_res;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;

    // predicted configuration
    logic                 pol_active_low;
    logic [LIMIT_W-1:0]   lim_long;
    logic [LIMIT_W-1:0]   lim_short;
    logic [LIMIT_W-1:0]   lim_min;

    // predicted press tracking and event ring
    logic                 is_held;
    logic                 long_sent;
    logic [TIME_W-1:0]    press_t0;
    bpcq_pkg::event_t     ring_slots [RING_DEPTH];
    int                   ring_wr;
    int                   ring_rd;

    // popped events still owed by the dut, oldest first
    bpcq_pkg::event_t     pending_events [$];

    // run control shared by the stimulus, receiver and checker
    logic                 idle_on;
    int                   hold_request;
    int                   error_count;
    int                   items_sent;
    logic [TIME_W-1:0]    wall_ms;

    button_press_classifier_queue #(
        .QUEUE_DEPTH (RING_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .action     (action),
        .pin_level  (pin_level),
        .now_ms     (now_ms),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .event_res  (event_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // free running clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // ring keeps one slot empty, a push into a full ring is lost
    task automatic ring_store(input bpcq_pkg::event_t ev);
        int nxt;
        nxt = (ring_wr + 1) % RING_DEPTH;
        if (nxt != ring_rd)
        begin
            ring_slots[ring_wr] = ev;
            ring_wr = nxt;
        end
    endtask

    // advance the predicted state for one accepted word
    task automatic classify_word(input logic act, input logic pin, input logic [TIME_W-1:0] t);
        logic              down;
        logic [TIME_W-1:0] held;
        bpcq_pkg::event_t  ev;
        if (act == bpcq_pkg::ACT_POP)
        begin
            // empty ring answers none and leaves the pointers alone
            ev = bpcq_pkg::EV_NONE;
            if (ring_rd != ring_wr)
            begin
                ev = ring_slots[ring_rd];
                ring_rd = (ring_rd + 1) % RING_DEPTH;
            end
            pending_events.push_back(ev);
        end
        else
        begin
            down = pol_active_low ? (pin == 1'b0) : (pin == 1'b1);
            held = t - press_t0;   // wraps modulo 2^32
            if (!is_held)
            begin
                // release while idle does nothing
                if (down)
                begin
                    is_held   = 1'b1;
                    long_sent = 1'b0;
                    press_t0  = t;
                end
            end
            else if (down)
            begin
                // one long event per hold
                if (!long_sent && held > TIME_W'(lim_long))
                begin
                    long_sent = 1'b1;
                    ring_store(bpcq_pkg::EV_LONG);
                end
            end
            else
            begin
                if (!long_sent && held > TIME_W'(lim_min) && held < TIME_W'(lim_short))
                    ring_store(bpcq_pkg::EV_SHORT);
                is_held   = 1'b0;
                long_sent = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // compare every taken result word with the oldest owed event
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_events.size() == 0)
                report_mismatch("result word with nothing owed", int'(event_res), -1);
            else if (event_res !== pending_events[0])
            begin
                report_mismatch("event_res", int'(event_res), int'(pending_events[0]));
                void'(pending_events.pop_front());
            end
            else
                void'(pending_events.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts plus an occasional long hold-off
    // ------------------------------------------------------------------

    initial
    begin
        int burst;
        int hold_left;
        burst     = 0;
        hold_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                // long hold-off so the result buffer fills and the input stalls
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                res_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 13) - 1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run after too long with no word moving
    // ------------------------------------------------------------------

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no progress for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // item sender, called at a falling edge and returns at one
    // ------------------------------------------------------------------

    task automatic send_word(input logic act, input logic pin, input logic [TIME_W-1:0] t);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        pin_level  <= pin;
        now_ms     <= t;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        classify_word(act, pin, t);
        items_sent++;
        @(negedge clk);
    endtask

    // pop with random junk on the poll fields
    task automatic send_pop();
        send_word(bpcq_pkg::ACT_POP, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // drop valid and wait until no event is owed and polls have landed
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (POLL_SETTLE) @(negedge clk);
    endtask

    // one register write, leaves cfg_valid high for a following write
    task automatic write_register(input bpcq_pkg::cfg_idx_t idx,
                                  input logic [LIMIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bpcq_pkg::CFG_ACTIVE_LOW:  pol_active_low = val[0];
            bpcq_pkg::CFG_LONG_LIMIT:  lim_long       = val;
            bpcq_pkg::CFG_SHORT_LIMIT: lim_short      = val;
            bpcq_pkg::CFG_MIN_PRESS:   lim_min        = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // full configuration, only with the block idle
    task automatic apply_setting(input logic al, input logic [LIMIT_W-1:0] lng,
                                 input logic [LIMIT_W-1:0] sht, input logic [LIMIT_W-1:0] mn);
        wait_drained();
        write_register(bpcq_pkg::CFG_ACTIVE_LOW, {{(LIMIT_W-1){1'b0}}, al});
        write_register(bpcq_pkg::CFG_LONG_LIMIT, lng);
        write_register(bpcq_pkg::CFG_SHORT_LIMIT, sht);
        write_register(bpcq_pkg::CFG_MIN_PRESS, mn);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // press shapes
    // ------------------------------------------------------------------

    // hold times clustered on the classification boundaries
    function automatic logic [TIME_W-1:0] pick_hold();
        case ($urandom_range(0, 9))
            0: return TIME_W'(lim_min);
            1: return TIME_W'(lim_min) + 1;
            2: return TIME_W'(lim_short) - 1;   // wraps huge when the limit is zero
            3: return TIME_W'(lim_short);
            4: return TIME_W'(lim_long);
            5: return TIME_W'(lim_long) + 1;
            6: return TIME_W'(lim_long) + TIME_W'($urandom_range(2, 500));
            7: return TIME_W'($urandom_range(0, 400));
            8: return TIME_W'($urandom_range(0, 70000));
            default: return $urandom;
        endcase
    endfunction

    // press, a few held polls, release
    task automatic press_sequence();
        logic              dn;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] t0;
        int                n_mid;
        int                k;
        dn      = ~pol_active_low;
        hold_ms = pick_hold();
        t0      = wall_ms;
        n_mid   = $urandom_range(0, 3);
        send_word(bpcq_pkg::ACT_POLL, dn, t0);
        for (k = 1; k <= n_mid; k++)
            send_word(bpcq_pkg::ACT_POLL, dn, t0 + (hold_ms / (n_mid + 1)) * k);
        // held poll right at the long boundary
        if ($urandom_range(0, 2) == 0)
            send_word(bpcq_pkg::ACT_POLL, dn,
                      t0 + TIME_W'(lim_long) + TIME_W'($urandom_range(0, 1)));
        send_word(bpcq_pkg::ACT_POLL, ~dn, t0 + hold_ms);
        wall_ms = t0 + hold_ms + TIME_W'($urandom_range(1, 3000));
    endtask

    // press that yields one long event when no press is already being tracked
    task automatic long_press();
        logic              dn;
        logic [TIME_W-1:0] t0;
        dn = ~pol_active_low;
        t0 = wall_ms;
        send_word(bpcq_pkg::ACT_POLL, dn, t0);
        send_word(bpcq_pkg::ACT_POLL, dn, t0 + TIME_W'(lim_long) + 1);
        send_word(bpcq_pkg::ACT_POLL, ~dn, t0 + TIME_W'(lim_long) + 2);
        wall_ms = t0 + TIME_W'(lim_long) + TIME_W'($urandom_range(3, 2000));
    endtask

    // bouncing pin, broken press
    task automatic bounce_sequence();
        int n;
        int k;
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
        begin
            send_word(bpcq_pkg::ACT_POLL, 1'($urandom_range(0, 1)), wall_ms);
            wall_ms += TIME_W'($urandom_range(0, 200));
        end
    endtask

    // mostly well formed presses with pops, some noise
    task automatic run_random_phase(input int n_items);
        int first;
        int k;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 19) == 0)
                wall_ms = $urandom;   // jump so every timestamp bit moves
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: press_sequence();
                6: long_press();
                7:
                begin
                    for (k = $urandom_range(1, 4); k > 0; k--)
                        send_pop();
                end
                8: send_word(bpcq_pkg::ACT_POLL, 1'($urandom_range(0, 1)), $urandom);
                default: bounce_sequence();
            endcase
            if ($urandom_range(0, 1) == 0)
                send_pop();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // boundaries under the reset configuration, pin low is a press
    task automatic test_directed();
        send_word(bpcq_pkg::ACT_POP, 1'b1, 32'hFFFF_FFFF);    // empty ring gives none
        send_word(bpcq_pkg::ACT_POLL, 1'b1, 32'h0000_0000);   // release while idle
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'hFFFF_FFE0);   // press just before wrap
        send_word(bpcq_pkg::ACT_POLL, 1'b1, 32'h0000_0012);   // held 50 across wrap, short
        send_word(bpcq_pkg::ACT_POP, 1'b0, 32'h0000_0000);
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd1000);
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd1800);   // exactly the long limit, nothing
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd1801);   // long
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd5000);   // only one long per hold
        send_word(bpcq_pkg::ACT_POLL, 1'b1, 32'd5001);   // no short after long
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd6000);
        send_word(bpcq_pkg::ACT_POLL, 1'b1, 32'd6030);   // at the floor, nothing
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd7000);
        send_word(bpcq_pkg::ACT_POLL, 1'b1, 32'd7031);   // just above the floor, short
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd8000);
        send_word(bpcq_pkg::ACT_POLL, 1'b1, 32'd8299);   // just below the short limit, short
        send_word(bpcq_pkg::ACT_POLL, 1'b0, 32'd9000);
        send_word(bpcq_pkg::ACT_POLL, 1'b1, 32'd9300);   // at the short limit, nothing
        repeat (4) send_pop();                           // long, short, short, none
        wall_ms = 32'd20000;
    endtask

    // ten events into seven usable slots, then drain past empty
    task automatic test_ring_full();
        repeat (10) long_press();
        repeat (9) send_pop();
    endtask

    // receiver holds off while the sender keeps pushing pops
    task automatic test_backpressure();
        hold_request = 240;
        repeat (20)
        begin
            long_press();
            send_pop();
            send_pop();
        end
    endtask

    // sender stops until every owed event has come back
    task automatic test_drain_pause();
        run_random_phase(20);
        item_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        run_random_phase(20);
    endtask

    // sweep of settings, extremes included
    task automatic test_config_sweep();
        apply_setting(1'b0, 16'd800, 16'd300, 16'd30);
        run_random_phase(210);
        apply_setting(1'b1, 16'd0, 16'hFFFF, 16'd0);
        run_random_phase(210);
        apply_setting(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        run_random_phase(210);
        apply_setting(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);   // short can never fire
        run_random_phase(210);
        apply_setting(1'b0, 16'd50, 16'd40, 16'd10);      // long just above short
        run_random_phase(210);
        apply_setting(1'($urandom_range(0, 1)), 16'($urandom_range(0, 1200)),
                      16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)));
        run_random_phase(210);
        apply_setting(1'b1, 16'd800, 16'd300, 16'd30);
        test_drain_pause();
    endtask

    // last stretch with no idling on either side
    task automatic test_full_rate();
        apply_setting(1'($urandom_range(0, 1)), 16'($urandom_range(0, 1000)),
                      16'($urandom_range(0, 500)), 16'($urandom_range(0, 200)));
        idle_on = 1'b0;
        run_random_phase(210);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int k;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        action     <= bpcq_pkg::ACT_POLL;
        pin_level  <= 1'b1;
        now_ms     <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= bpcq_pkg::CFG_ACTIVE_LOW;
        cfg_data   <= '0;
        idle_on        = 1'b1;
        hold_request   = 0;
        error_count    = 0;
        items_sent     = 0;
        wall_ms        = '0;
        // state after reset
        pol_active_low = 1'b1;
        lim_long       = 16'd800;
        lim_short      = 16'd300;
        lim_min        = 16'd30;
        is_held        = 1'b0;
        long_sent      = 1'b0;
        press_t0       = '0;
        ring_wr        = 0;
        ring_rd        = 0;
        for (k = 0; k < RING_DEPTH; k++)
            ring_slots[k] = bpcq_pkg::EV_NONE;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_ring_full();
        test_backpressure();
        test_config_sweep();
        test_full_rate();

        // let the last results come back
        item_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_events.size() != 0)
            report_mismatch("events never returned", 0, pending_events.size());

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/bpcq_pkg.sv
design/button_press_classifier_queue.sv
dv/button_press_classifier_queue_tb.sv
